[design/psfp_pkg.sv]
// Package for the particle sensor frame parser.
// Holds shared widths, protocol bytes, status codes and the frame result type.
// No dependencies.
package psfp_pkg;

  localparam int unsigned FRAME_LEN_DEF = 20;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned SUM_W  = 24;
  localparam int unsigned CNT_W  = 8;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h16;
  localparam logic [BYTE_W-1:0] HEAD_ONE  = 8'h11;
  localparam logic [BYTE_W-1:0] HEAD_TWO  = 8'h0B;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 8'hFF;

  // command codes
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    STATUS_VALID  = 2'd0,
    STATUS_HEADER = 2'd1,
    STATUS_CSUM   = 2'd2
  } frame_status_e;

  typedef struct packed {
    logic              done;
    frame_status_e     status;
    logic [VAL_W-1:0]  value;
  } frame_result_t;

endpackage

[design/psfp_frame.sv]
// Frame tracker and statistics registers of the particle sensor frame parser.
// Depends on psfp_pkg.
module psfp_frame #(
  parameter int unsigned FRAME_LEN = psfp_pkg::FRAME_LEN_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          command_i,
  input  logic [psfp_pkg::BYTE_W-1:0]   rx_byte_i,
  output psfp_pkg::frame_result_t       result_o,
  output logic [psfp_pkg::SUM_W-1:0]    sum_o,
  output logic [psfp_pkg::VAL_W-1:0]    peak_o,
  output logic [psfp_pkg::CNT_W-1:0]    count_o
);

  localparam int unsigned PosW = $clog2(FRAME_LEN);
  localparam logic [PosW-1:0] PosLast = PosW'(FRAME_LEN - 1);
  localparam logic [PosW-1:0] PosHeadOne = PosW'(1);
  localparam logic [PosW-1:0] PosHeadTwo = PosW'(2);
  localparam logic [PosW-1:0] PosHigh = PosW'(5);
  localparam logic [PosW-1:0] PosLow = PosW'(6);

  logic [PosW-1:0]                 pos_q, pos_d;
  logic [psfp_pkg::BYTE_W-1:0]     check_q, check_d;
  logic                            hdr_q, hdr_d;
  logic [psfp_pkg::BYTE_W-1:0]     high_q, high_d;
  logic [psfp_pkg::BYTE_W-1:0]     low_q, low_d;
  logic [psfp_pkg::SUM_W-1:0]      sum_q, sum_d;
  logic [psfp_pkg::VAL_W-1:0]      peak_q, peak_d;
  logic [psfp_pkg::CNT_W-1:0]      count_q, count_d;

  logic                            active;
  logic                            last;
  logic [psfp_pkg::VAL_W-1:0]      value;
  psfp_pkg::frame_status_e         status;

  always_comb begin
    active = step_i && (command_i == psfp_pkg::CMD_BYTE) &&
             ((pos_q != '0) || (rx_byte_i == psfp_pkg::SYNC_BYTE));
    last   = (pos_q == PosLast);

    check_d = check_q + rx_byte_i;
    hdr_d   = hdr_q;
    if ((pos_q == PosHeadOne) && (rx_byte_i != psfp_pkg::HEAD_ONE)) begin
      hdr_d = 1'b0;
    end
    if ((pos_q == PosHeadTwo) && (rx_byte_i != psfp_pkg::HEAD_TWO)) begin
      hdr_d = 1'b0;
    end
    high_d = (pos_q == PosHigh) ? rx_byte_i : high_q;
    low_d  = (pos_q == PosLow) ? rx_byte_i : low_q;
    value  = {high_d, low_d};

    if (!hdr_d) begin
      status = psfp_pkg::STATUS_HEADER;
    end else if (check_d != '0) begin
      status = psfp_pkg::STATUS_CSUM;
    end else begin
      status = psfp_pkg::STATUS_VALID;
    end

    pos_d = pos_q + PosW'(1);
    if (last) begin
      pos_d   = '0;
      check_d = '0;
      hdr_d   = 1'b1;
      high_d  = '0;
      low_d   = '0;
    end

    sum_d   = sum_q;
    peak_d  = peak_q;
    count_d = count_q;
    if (step_i && (command_i == psfp_pkg::CMD_CLEAR)) begin
      sum_d   = '0;
      peak_d  = '0;
      count_d = '0;
    end else if (active && last && (status == psfp_pkg::STATUS_VALID)) begin
      if (count_q != psfp_pkg::COUNT_MAX) begin
        sum_d   = sum_q + psfp_pkg::SUM_W'(value);
        count_d = count_q + psfp_pkg::CNT_W'(1);
      end
      if (value > peak_q) begin
        peak_d = value;
      end
    end

    result_o.done   = active && last;
    result_o.status = (active && last) ? status : psfp_pkg::STATUS_VALID;
    result_o.value  = (active && last) ? value : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      check_q <= '0;
      hdr_q   <= 1'b1;
      high_q  <= '0;
      low_q   <= '0;
      sum_q   <= '0;
      peak_q  <= '0;
      count_q <= '0;
    end else begin
      if (active) begin
        pos_q   <= pos_d;
        check_q <= check_d;
        hdr_q   <= hdr_d;
        high_q  <= high_d;
        low_q   <= low_d;
      end
      sum_q   <= sum_d;
      peak_q  <= peak_d;
      count_q <= count_d;
    end
  end

  assign sum_o   = sum_q;
  assign peak_o  = peak_q;
  assign count_o = count_q;

endmodule

[design/psfp_div.sv]
// Restoring divider, one quotient bit per cycle, for the running average.
// Depends on psfp_pkg.
module psfp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [psfp_pkg::SUM_W-1:0]  dividend_i,
  input  logic [psfp_pkg::CNT_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [psfp_pkg::VAL_W-1:0]  quotient_o
);

  localparam int unsigned StepW = $clog2(psfp_pkg::SUM_W);
  localparam logic [StepW-1:0] StepLast = StepW'(psfp_pkg::SUM_W - 1);

  logic                          busy_q;
  logic                          done_q;
  logic [StepW-1:0]              step_q;
  logic [psfp_pkg::CNT_W-1:0]    rem_q, rem_d;
  logic [psfp_pkg::SUM_W-1:0]    quo_q, quo_d;
  logic [psfp_pkg::CNT_W-1:0]    div_q;

  logic [psfp_pkg::CNT_W:0]      rem_sh;
  logic [psfp_pkg::CNT_W+1:0]    diff;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    rem_sh = {rem_q, quo_q[psfp_pkg::SUM_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, div_q};
    if (!diff[psfp_pkg::CNT_W+1]) begin
      rem_d = diff[psfp_pkg::CNT_W-1:0];
      quo_d = {quo_q[psfp_pkg::SUM_W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[psfp_pkg::CNT_W-1:0];
      quo_d = {quo_q[psfp_pkg::SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + StepW'(1);
        if (step_q == StepLast) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // mean never exceeds the largest reading, so the low bits hold it all
  assign done_o     = done_q;
  assign quotient_o = quo_q[psfp_pkg::VAL_W-1:0];

endmodule

[design/particle_sensor_frame_parser_top.sv]
// Particle sensor frame parser, top level: one byte or clear in, one status
// transfer out per item. Depends on psfp_pkg, psfp_frame and psfp_div.
//
// Each input transfer carries either a received serial byte or a clear
// command. The parser hunts for sync byte 0x16, collects FRAME_LEN bytes,
// checks the 0x11/0x0B header and the zero 8-bit checksum, and on a good
// frame folds byte5*256+byte6 into a running sum, peak and saturating count.
// Every input transfer yields exactly one output transfer with the frame
// outcome (when the byte closed a frame) and the current average, peak and
// count. An item occupies the block from acceptance until the next item can
// be taken: the frame and statistics registers are updated, the divider is
// loaded, the bit-serial restoring divider forms sum/count for the average,
// and the output register is loaded. The output register holds a finished
// result while the next item is accepted; only when a second result is ready
// and the first is still stalled does the block wait for the output side.
module particle_sensor_frame_parser_top #(
  parameter int unsigned FRAME_LEN = psfp_pkg::FRAME_LEN_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        command_i,
  input  logic [psfp_pkg::BYTE_W-1:0] rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        frame_done_o,
  output logic [1:0]                  frame_status_o,
  output logic [psfp_pkg::VAL_W-1:0]  reading_o,
  output logic [psfp_pkg::VAL_W-1:0]  average_o,
  output logic [psfp_pkg::VAL_W-1:0]  peak_o,
  output logic [psfp_pkg::CNT_W-1:0]  sample_count_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_HOLD  = 4'b1000
  } state_e;

  state_e                        state_q, state_d;

  logic                          in_xfer;
  logic                          out_xfer;
  logic                          out_free;
  logic                          load_out;

  psfp_pkg::frame_result_t       frame_res;
  psfp_pkg::frame_result_t       res_q;
  logic [psfp_pkg::SUM_W-1:0]    stat_sum;
  logic [psfp_pkg::VAL_W-1:0]    stat_peak;
  logic [psfp_pkg::CNT_W-1:0]    stat_count;

  logic                          div_start;
  logic                          div_done;
  logic [psfp_pkg::VAL_W-1:0]    div_quo;

  logic                          out_valid_q;
  psfp_pkg::frame_result_t       out_res_q;
  logic [psfp_pkg::VAL_W-1:0]    out_avg_q;
  logic [psfp_pkg::VAL_W-1:0]    out_peak_q;
  logic [psfp_pkg::CNT_W-1:0]    out_count_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_xfer   = out_valid_q && !out_stall_i;
  // output register is free if empty or being drained this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign div_start  = (state_q == ST_START);
  assign load_out   = ((state_q == ST_DIV) && div_done && out_free) ||
                      ((state_q == ST_HOLD) && out_free);

  // frame tracking and statistics update happen on the accepting edge
  psfp_frame #(
    .FRAME_LEN (FRAME_LEN)
  ) u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (in_xfer),
    .command_i (command_i),
    .rx_byte_i (rx_byte_i),
    .result_o  (frame_res),
    .sum_o     (stat_sum),
    .peak_o    (stat_peak),
    .count_o   (stat_count)
  );

  // stats are stable while the divider runs: no new item is taken then
  psfp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (stat_sum),
    .divisor_i  (stat_count),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= frame_res;
    end
    if (load_out) begin
      out_res_q   <= res_q;
      // empty statistics report a zero mean
      out_avg_q   <= (stat_count == '0) ? '0 : div_quo;
      out_peak_q  <= stat_peak;
      out_count_q <= stat_count;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_done_o   = out_res_q.done;
  assign frame_status_o = out_res_q.status;
  assign reading_o      = out_res_q.value;
  assign average_o      = out_avg_q;
  assign peak_o         = out_peak_q;
  assign sample_count_o = out_count_q;

  // an accepted item always starts the divider on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_START))
    else $error("accepted item did not launch the divider");

  // the divider only finishes while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide phase");

  // a new result only appears after a divide phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past((state_q == ST_DIV) || (state_q == ST_HOLD)))
    else $error("result loaded without a finished divide");

  // the mean of the readings never exceeds their maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_avg_q <= out_peak_q))
    else $error("average exceeds peak");

  // no samples means a zero average
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_count_q == '0)) |-> (out_avg_q == '0))
    else $error("nonzero average with empty statistics");

endmodule

[tb/sv/tb_top.sv]
// Testbench for the particle sensor frame parser top level.
// Holds the stats scoreboard, the byte/frame drivers and the result monitor.
// Depends on psfp_pkg and particle_sensor_frame_parser_top.
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAME_BYTES    = psfp_pkg::FRAME_LEN_DEF;
  localparam int TOTAL_ITEMS    = 1150;  // input transfers over the whole run
  localparam int HOLD_CYCLES    = 500;   // long output hold-off to back up the input
  localparam int DRAIN_CYCLES   = 120;   // quiet tail after the last expected result
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either side

  // one status transfer as seen on the output side
  typedef struct packed {
    logic                        done;
    psfp_pkg::frame_status_e     status;
    logic [psfp_pkg::VAL_W-1:0]  reading;
    logic [psfp_pkg::VAL_W-1:0]  average;
    logic [psfp_pkg::VAL_W-1:0]  peak;
    logic [psfp_pkg::CNT_W-1:0]  count;
  } stats_report_t;

  // Scoreboard: mirrors the frame parser and the running statistics,
  // queues the report each accepted input produces and checks results in order.
  class frame_stats_board;
    logic [4:0]                  pos;
    logic [psfp_pkg::BYTE_W-1:0] csum;
    logic                        hdr_ok;
    logic [psfp_pkg::BYTE_W-1:0] val_hi;
    logic [psfp_pkg::BYTE_W-1:0] val_lo;
    logic [psfp_pkg::SUM_W-1:0]  sum;
    logic [psfp_pkg::VAL_W-1:0]  peak;
    logic [psfp_pkg::CNT_W-1:0]  cnt;
    stats_report_t               expected_reports[$];
    int                          errors;

    function new();
      restart_frame();
      clear_stats();
      errors = 0;
    endfunction

    function void restart_frame();
      pos    = '0;
      csum   = '0;
      hdr_ok = 1'b1;
      val_hi = '0;
      val_lo = '0;
    endfunction

    function void clear_stats();
      sum  = '0;
      peak = '0;
      cnt  = '0;
    endfunction

    // accepted input transfer: advance the parser and queue the expected report
    function void note_transfer(logic cmd, logic [psfp_pkg::BYTE_W-1:0] rx);
      stats_report_t              rep;
      logic [psfp_pkg::VAL_W-1:0] value;
      logic [psfp_pkg::SUM_W-1:0] quot;
      rep   = '0;
      value = '0;
      if (cmd == psfp_pkg::CMD_CLEAR) begin
        // frame in progress survives, only the stats go
        clear_stats();
      end else if (pos != 0 || rx == psfp_pkg::SYNC_BYTE) begin
        if (pos == 1 && rx != psfp_pkg::HEAD_ONE) hdr_ok = 1'b0;
        if (pos == 2 && rx != psfp_pkg::HEAD_TWO) hdr_ok = 1'b0;
        if (pos == 5) val_hi = rx;
        if (pos == 6) val_lo = rx;
        csum = csum + rx;
        if (pos >= FRAME_BYTES - 1) begin
          value    = {val_hi, val_lo};
          rep.done = 1'b1;
          rep.reading = value;
          // header wins over checksum when both are bad
          if (!hdr_ok) begin
            rep.status = psfp_pkg::STATUS_HEADER;
          end else if (csum != 0) begin
            rep.status = psfp_pkg::STATUS_CSUM;
          end else begin
            rep.status = psfp_pkg::STATUS_VALID;
            // saturated count freezes sum and count, peak still tracks
            if (cnt < psfp_pkg::COUNT_MAX) begin
              sum = sum + psfp_pkg::SUM_W'(value);
              cnt = cnt + 1'b1;
            end
            if (value > peak) peak = value;
          end
          restart_frame();
        end else begin
          pos = pos + 1'b1;
        end
      end
      if (cnt != 0) begin
        quot = sum / psfp_pkg::SUM_W'(cnt);
        rep.average = quot[psfp_pkg::VAL_W-1:0];
      end
      rep.peak  = peak;
      rep.count = cnt;
      expected_reports.push_back(rep);
    endfunction

    function void field_check(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                 act_val);
        errors++;
      end
    endfunction

    // accepted output transfer: compare against the oldest expected report
    function void check_report(stats_report_t got);
      stats_report_t exp_rep;
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual done=%0d reading=%0d",
                 $time, got.done, got.reading);
        errors++;
        return;
      end
      exp_rep = expected_reports.pop_front();
      field_check("frame_done", exp_rep.done, got.done);
      field_check("frame_status", exp_rep.status, got.status);
      field_check("reading", exp_rep.reading, got.reading);
      field_check("average", exp_rep.average, got.average);
      field_check("peak", exp_rep.peak, got.peak);
      field_check("sample_count", exp_rep.count, got.count);
    endfunction
  endclass

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  // block interface, every input known from time zero
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic                        command_i   = psfp_pkg::CMD_BYTE;
  logic [psfp_pkg::BYTE_W-1:0] rx_byte_i   = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic                        frame_done_o;
  logic [1:0]                  frame_status_o;
  logic [psfp_pkg::VAL_W-1:0]  reading_o;
  logic [psfp_pkg::VAL_W-1:0]  average_o;
  logic [psfp_pkg::VAL_W-1:0]  peak_o;
  logic [psfp_pkg::CNT_W-1:0]  sample_count_o;

  particle_sensor_frame_parser_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_done_o   (frame_done_o),
    .frame_status_o (frame_status_o),
    .reading_o      (reading_o),
    .average_o      (average_o),
    .peak_o         (peak_o),
    .sample_count_o (sample_count_o)
  );

  frame_stats_board board = new();

  // idle knobs, changed per phase by the main sequence
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // hold-off handshake between the main sequence and the receiver process
  int hold_requests = 0;
  int sent_items    = 0;   // every accepted input transfer
  int quiet_cycles  = 0;

  // Receiver: decides stall at each falling edge. A pending hold-off request
  // turns into a long solid stall, counted down here cycle by cycle.
  initial begin : receiver
    int hold_served;
    int hold_left;
    hold_served = 0;
    hold_left   = 0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Monitor and watchdog: sample at the rising edge. A result transfer goes
  // to the scoreboard; a long stretch with no transfer at all ends the run.
  always @(posedge clk_i) begin
    stats_report_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.done    = frame_done_o;
      got.status  = psfp_pkg::frame_status_e'(frame_status_o);
      got.reading = reading_o;
      got.average = average_o;
      got.peak    = peak_o;
      got.count   = sample_count_o;
      board.check_report(got);
    end
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               board.expected_reports.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // One input transfer. Payload changes at the falling edge; valid stays high
  // across back-to-back items unless the sender chooses to idle first.
  task automatic send_item(input logic cmd, input logic [psfp_pkg::BYTE_W-1:0] rx);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    rx_byte_i  <= rx;
    do @(posedge clk_i); while (in_stall_o);
    board.note_transfer(cmd, rx);
    sent_items++;
  endtask

  // Build and send a frame. bad_head bit 0/1 corrupts header byte 1/2,
  // bad_csum breaks the checksum, clear_at slips a clear in before that byte,
  // sent_len below the frame length cuts the frame short.
  task automatic send_frame(input logic [psfp_pkg::VAL_W-1:0] value,
                            input logic [1:0] bad_head, input logic bad_csum,
                            input int clear_at, input int sent_len);
    logic [psfp_pkg::BYTE_W-1:0] frame_bytes [FRAME_BYTES];
    logic [psfp_pkg::BYTE_W-1:0] csum;
    csum = '0;
    for (int i = 0; i < FRAME_BYTES; i++) frame_bytes[i] = 8'($urandom_range(255));
    frame_bytes[0] = psfp_pkg::SYNC_BYTE;
    frame_bytes[1] = psfp_pkg::HEAD_ONE ^
                     (bad_head[0] ? 8'($urandom_range(255, 1)) : 8'h00);
    frame_bytes[2] = psfp_pkg::HEAD_TWO ^
                     (bad_head[1] ? 8'($urandom_range(255, 1)) : 8'h00);
    frame_bytes[5] = value[15:8];
    frame_bytes[6] = value[7:0];
    for (int i = 0; i < FRAME_BYTES - 1; i++) csum = csum + frame_bytes[i];
    frame_bytes[FRAME_BYTES-1] = (8'h00 - csum) ^
                                 (bad_csum ? 8'($urandom_range(255, 1)) : 8'h00);
    for (int i = 0; i < sent_len; i++) begin
      if (i == clear_at) begin
        send_item(psfp_pkg::CMD_CLEAR, 8'($urandom_range(255)));
      end
      send_item(psfp_pkg::CMD_BYTE, frame_bytes[i]);
    end
  endtask

  function automatic logic [psfp_pkg::VAL_W-1:0] pick_reading();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return psfp_pkg::VAL_W'($urandom_range(65535));
  endfunction

  // Random traffic: mostly well-formed frames with random content, the rest
  // broken headers/checksums, cut frames, clears and line noise.
  task automatic random_burst();
    int kind;
    kind = $urandom_range(99);
    if (kind < 60) begin
      send_frame(pick_reading(), 2'b00, 1'b0, -1, FRAME_BYTES);
    end else if (kind < 70) begin
      send_frame(pick_reading(), 2'($urandom_range(3, 1)), 1'b0, -1, FRAME_BYTES);
    end else if (kind < 78) begin
      send_frame(pick_reading(), 2'b00, 1'b1, -1, FRAME_BYTES);
    end else if (kind < 82) begin
      send_frame(pick_reading(), 2'($urandom_range(3, 1)), 1'b1, -1, FRAME_BYTES);
    end else if (kind < 86) begin
      send_frame(pick_reading(), 2'b00, 1'b0, $urandom_range(FRAME_BYTES - 1, 1),
                 FRAME_BYTES);
    end else if (kind < 91) begin
      send_frame(pick_reading(), 2'b00, 1'b0, -1, $urandom_range(FRAME_BYTES - 1, 1));
    end else if (kind < 96) begin
      repeat ($urandom_range(4, 1)) begin
        send_item(psfp_pkg::CMD_BYTE, 8'($urandom_range(255)));
      end
    end else begin
      send_item(psfp_pkg::CMD_CLEAR, 8'($urandom_range(255)));
    end
  endtask

  // Main sequence
  initial begin : main_seq
    int phase_goal;
    int base_items;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: clear while hunting, noise that must be ignored, extreme
    // readings, each header byte wrong, bad checksum, both wrong, clear mid-frame
    send_item(psfp_pkg::CMD_CLEAR, 8'hFF);
    send_item(psfp_pkg::CMD_BYTE, 8'h00);
    send_item(psfp_pkg::CMD_BYTE, 8'hFF);
    send_item(psfp_pkg::CMD_BYTE, psfp_pkg::HEAD_ONE);
    send_item(psfp_pkg::CMD_BYTE, psfp_pkg::HEAD_TWO);
    send_frame(16'hFFFF, 2'b00, 1'b0, -1, FRAME_BYTES);
    send_frame(16'h0000, 2'b00, 1'b0, -1, FRAME_BYTES);
    send_frame(16'h1234, 2'b01, 1'b0, -1, FRAME_BYTES);
    send_frame(16'h4321, 2'b10, 1'b0, -1, FRAME_BYTES);
    send_frame(16'hABCD, 2'b00, 1'b1, -1, FRAME_BYTES);
    send_frame(16'h5A5A, 2'b01, 1'b1, -1, FRAME_BYTES);
    send_frame(16'h0101, 2'b00, 1'b0, 10, FRAME_BYTES);
    send_item(psfp_pkg::CMD_CLEAR, 8'h00);

    // random phases; the first one carries the long output hold-off
    base_items = sent_items;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 87; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 87; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      if (ph == 0) hold_requests++;
      phase_goal = base_items + ((TOTAL_ITEMS - base_items) * (ph + 1)) / 4;
      while (sent_items < phase_goal) random_burst();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain, then a quiet tail to catch anything extra
    while (board.expected_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.errors == 0 && board.expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[particle_sensor_frame_parser_top.f]
design/psfp_pkg.sv
design/psfp_frame.sv
design/psfp_div.sv
design/particle_sensor_frame_parser_top.sv
tb/sv/tb_top.sv
